### rtl/acp_pkg.sv
// Shared types, codes and fixed-point helpers for the affine constraint projection block.
`default_nettype none
package acp_pkg;

  localparam int MAX_VERTS_DEF    = 64;
  localparam int MAX_CONTROLS_DEF = 8;

  // columns per control, period of the column pattern, translation phase
  localparam int COLS_PER_CONTROL = 6;
  localparam int COL_PERIOD       = 3;
  localparam int POS_COL_PHASE    = 2;

  // quotient bits produced by the shared divider, one per cycle
  localparam int DIV_STEPS = 48;

  localparam logic [3:0] OP_LOAD_WEIGHT = 4'd0;
  localparam logic [3:0] OP_LOAD_MASS   = 4'd1;
  localparam logic [3:0] OP_LOAD_POS    = 4'd2;
  localparam logic [3:0] OP_LOAD_TARGET = 4'd3;
  localparam logic [3:0] OP_PREPARE     = 4'd4;
  localparam logic [3:0] OP_CLEAR_MULT  = 4'd5;
  localparam logic [3:0] OP_PROJECT     = 4'd6;
  localparam logic [3:0] OP_READ_POS    = 4'd7;
  localparam logic [3:0] OP_READ_MULT   = 4'd8;

  localparam logic [2:0] REG_ROT_COMP  = 3'd0;
  localparam logic [2:0] REG_POS_COMP  = 3'd1;
  localparam logic [2:0] REG_TIME_STEP = 3'd2;
  localparam logic [2:0] REG_VERTS     = 3'd3;
  localparam logic [2:0] REG_CONTROLS  = 3'd4;

  localparam logic [30:0] TIME_STEP_RESET = 31'd1092;
  localparam logic [6:0]  VERTS_RESET     = 7'd64;
  localparam logic [3:0]  CONTROLS_RESET  = 4'd8;

  localparam int PADDR_W = 5;

  typedef struct packed {
    logic [3:0]         op;
    logic [5:0]         vert_index;
    logic               axis;
    logic [5:0]         param_index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_value;
    logic               source;
    logic               status;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] ext48(input logic signed [31:0] x);
    return {{16{x[31]}}, x};
  endfunction

  // product >> 16 with floor, saturated
  function automatic logic signed [31:0] fx_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    return sat32(s[47:0]);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    logic [31:0] n;
    n = -x;
    return x[31] ? n : x;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] x);
    if (x == 32'sh8000_0000) begin
      return 32'sh7FFF_FFFF;
    end else begin
      return -x;
    end
  endfunction

  function automatic logic signed [31:0] div_finish(input logic [47:0] q, input logic neg);
    logic [47:0] n;
    n = -q;
    if (neg) begin
      if (q > 48'h0000_8000_0000) begin
        return 32'sh8000_0000;
      end else begin
        return n[31:0];
      end
    end else if (q > 48'h0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else begin
      return q[31:0];
    end
  endfunction

endpackage
`default_nettype wire

### rtl/affine_constraint_projection.sv
// Top level: stores, sequencer, shared multiplier and shared divider.
//
//  channel  | signals                          | direction | moves
//  item     | item_valid/item_ready/item       | in        | one in_item_t per transfer
//  result   | result_valid/result_ready/result | out       | one out_item_t per transfer
//  config   | psel/penable/pwrite/paddr/...    | in/out    | APB register access
//
// Loads are written as they are accepted; reads return their result through S_READ.
// Clear multipliers sweeps all 2^CB multiplier entries. Prepare and project walk the
// matrices with one 32x32 multiplier and one radix-2 divider (48 quotient bits).
// After reset a clearing pass zeroes the weights and multipliers; items are not taken
// meanwhile, config writes are. A pending result blocks new items until it is
// transferred.
`default_nettype none
module affine_constraint_projection #(
  parameter int MAX_VERTS    = acp_pkg::MAX_VERTS_DEF,
  parameter int MAX_CONTROLS = acp_pkg::MAX_CONTROLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire acp_pkg::in_item_t           item,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output acp_pkg::out_item_t               result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [acp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  localparam int VAW   = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int RB    = VAW + 1;
  localparam int NCOLS = acp_pkg::COLS_PER_CONTROL * MAX_CONTROLS;
  localparam int CB    = $clog2(NCOLS);
  localparam int WAW   = RB + CB;

  localparam logic [5:0] S_CLEAR    = 6'd0;
  localparam logic [5:0] S_IDLE     = 6'd1;
  localparam logic [5:0] S_READ     = 6'd2;
  localparam logic [5:0] S_MCLR     = 6'd3;
  localparam logic [5:0] S_DIV      = 6'd4;
  localparam logic [5:0] S_PR_DT    = 6'd5;
  localparam logic [5:0] S_PR_ROT   = 6'd6;
  localparam logic [5:0] S_PR_POS   = 6'd7;
  localparam logic [5:0] S_PR_INIT  = 6'd8;
  localparam logic [5:0] S_MW_RD    = 6'd9;
  localparam logic [5:0] S_MW_MUL   = 6'd10;
  localparam logic [5:0] S_MW_WR    = 6'd11;
  localparam logic [5:0] S_RM_RD    = 6'd12;
  localparam logic [5:0] S_RM_MUL   = 6'd13;
  localparam logic [5:0] S_RM_ACC   = 6'd14;
  localparam logic [5:0] S_RM_WR    = 6'd15;
  localparam logic [5:0] S_EM_START = 6'd16;
  localparam logic [5:0] S_EM_RD0   = 6'd17;
  localparam logic [5:0] S_EM_RD1   = 6'd18;
  localparam logic [5:0] S_EM_RD2   = 6'd19;
  localparam logic [5:0] S_EM_SQ    = 6'd20;
  localparam logic [5:0] S_EM_ACC   = 6'd21;
  localparam logic [5:0] S_EM_WR    = 6'd22;
  localparam logic [5:0] S_PJ_START = 6'd23;
  localparam logic [5:0] S_PJ1_RD   = 6'd24;
  localparam logic [5:0] S_PJ1_MUL  = 6'd25;
  localparam logic [5:0] S_PJ1_ACC  = 6'd26;
  localparam logic [5:0] S_PJ2_RD   = 6'd27;
  localparam logic [5:0] S_PJ2_MUL  = 6'd28;
  localparam logic [5:0] S_PJ2_ACC  = 6'd29;
  localparam logic [5:0] S_PJ_C     = 6'd30;
  localparam logic [5:0] S_PJ_DL    = 6'd31;
  localparam logic [5:0] S_PJ_UPD   = 6'd32;
  localparam logic [5:0] S_PJ3_RD   = 6'd33;
  localparam logic [5:0] S_PJ3_MUL1 = 6'd34;
  localparam logic [5:0] S_PJ3_MUL2 = 6'd35;
  localparam logic [5:0] S_PJ3_WR   = 6'd36;

  // configuration registers
  logic [30:0] rotation_compliance;
  logic [30:0] position_compliance;
  logic [30:0] time_step;
  logic [6:0]  vertex_count;
  logic [3:0]  control_count;

  logic [5:0]  state;
  logic [5:0]  ret;
  logic [WAW-1:0] clr_cnt;
  logic [RB-1:0]  cr;
  logic [CB-1:0]  cj;
  logic [CB-1:0]  ck;
  logic [1:0]     m3;
  logic signed [47:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] dt2, rot_t, pos_t, t1, s1, cval, dl, divq;
  logic           err;
  logic           rd_src, rd_zero;

  logic [47:0] dv_num;
  logic [31:0] dv_den, dv_rem;
  logic        dv_neg;
  logic [5:0]  dv_cnt;

  logic [VAW-1:0] nvm1;
  logic [RB-1:0]  rows_last;
  logic [CB-1:0]  cols_last;

  logic accept, v_ok, p_ok, cfg_wr;
  logic signed [31:0] prod_fx;

  // RAM ports
  logic           w_we;
  logic [WAW-1:0] w_wa, w_ra;
  logic [31:0]    w_wd, w_rd;
  logic           ms_we;
  logic [63:0]    ms_rd;
  logic           pos_we;
  logic [RB-1:0]  pos_wa, pos_ra;
  logic [31:0]    pos_wd, pos_rd;
  logic           tg_we;
  logic [31:0]    tg_rd;
  logic           mwr_we;
  logic [WAW-1:0] mwr_ra;
  logic [31:0]    mwr_rd;
  logic           rm_we;
  logic [31:0]    rm_rd;
  logic           em_we;
  logic [31:0]    em_rd;
  logic           ml_we;
  logic [CB-1:0]  ml_wa, ml_ra;
  logic [31:0]    ml_wd, ml_rd;

  logic signed [31:0] mul_a, mul_b;
  logic               div_go;
  logic signed [31:0] div_a, div_b;
  logic [5:0]         div_ret;

  logic [32:0] rem_sh;
  logic        qbit;
  logic [47:0] q_new;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[4:2])
      acp_pkg::REG_ROT_COMP:  prdata = {1'b0, rotation_compliance};
      acp_pkg::REG_POS_COMP:  prdata = {1'b0, position_compliance};
      acp_pkg::REG_TIME_STEP: prdata = {1'b0, time_step};
      acp_pkg::REG_VERTS:     prdata = {25'd0, vertex_count};
      acp_pkg::REG_CONTROLS:  prdata = {28'd0, control_count};
      default:                prdata = '0;
    endcase
  end

  // counts in force, clamped to the supported range
  always_comb begin
    if (vertex_count == 7'd0) begin
      nvm1 = '0;
    end else if (32'(vertex_count) > MAX_VERTS) begin
      nvm1 = VAW'(MAX_VERTS - 1);
    end else begin
      nvm1 = VAW'(vertex_count - 7'd1);
    end
    if (control_count == 4'd0) begin
      cols_last = CB'(acp_pkg::COLS_PER_CONTROL - 1);
    end else if (32'(control_count) > MAX_CONTROLS) begin
      cols_last = CB'(NCOLS - 1);
    end else begin
      cols_last = CB'(acp_pkg::COLS_PER_CONTROL * 32'(control_count) - 1);
    end
    rows_last = {nvm1, 1'b1};
  end

  assign item_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;
  assign v_ok       = 32'(item.vert_index) < MAX_VERTS;
  assign p_ok       = 32'(item.param_index) < NCOLS;
  assign prod_fx    = acp_pkg::fx_sat(prod);

  // memory addressing and writes
  always_comb begin
    w_we   = 1'b0;
    w_wa   = {RB'({item.vert_index, item.axis}), CB'(item.param_index)};
    w_wd   = item.value_a;
    w_ra   = (state == S_MW_RD) ? {cr, cj} : {cr, ck};
    ms_we  = accept && (item.op == acp_pkg::OP_LOAD_MASS) && v_ok;
    pos_we = 1'b0;
    pos_wa = RB'({item.vert_index, item.axis});
    pos_wd = item.value_a;
    pos_ra = (state == S_IDLE) ? RB'({item.vert_index, item.axis}) : cr;
    tg_we  = accept && (item.op == acp_pkg::OP_LOAD_TARGET) && p_ok;
    mwr_we = (state == S_MW_WR);
    mwr_ra = {cj, cr[RB-1:1], cr[0] | (state == S_EM_RD1)};
    rm_we  = (state == S_RM_WR);
    em_we  = (state == S_EM_WR);
    ml_we  = 1'b0;
    ml_wa  = clr_cnt[CB-1:0];
    ml_wd  = '0;
    ml_ra  = (state == S_IDLE) ? CB'(item.param_index) : cj;
    if (state == S_CLEAR) begin
      w_we  = 1'b1;
      w_wa  = clr_cnt;
      w_wd  = '0;
      ml_we = 1'b1;
    end else if (state == S_MCLR) begin
      ml_we = 1'b1;
    end else if (state == S_PJ_UPD) begin
      ml_we = 1'b1;
      ml_wa = cj;
      ml_wd = acp_pkg::sat32(acp_pkg::ext48(ml_rd) + acp_pkg::ext48(divq));
    end else if (state == S_PJ3_WR) begin
      pos_we = 1'b1;
      pos_wa = cr;
      pos_wd = acp_pkg::sat32(acp_pkg::ext48(pos_rd) + acp_pkg::ext48(prod_fx));
    end else if (accept) begin
      w_we   = (item.op == acp_pkg::OP_LOAD_WEIGHT) && v_ok && p_ok;
      pos_we = (item.op == acp_pkg::OP_LOAD_POS) && v_ok;
    end
  end

  acp_ram #(.WIDTH(32), .DEPTH(2**WAW)) u_weight (
    .clk, .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));

  acp_ram #(.WIDTH(64), .DEPTH(2**VAW)) u_mass (
    .clk, .we(ms_we), .waddr(VAW'(item.vert_index)),
    .wdata({item.value_a, item.value_b}), .raddr(cr[RB-1:1]), .rdata(ms_rd));

  acp_ram #(.WIDTH(32), .DEPTH(2**RB)) u_pos (
    .clk, .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra), .rdata(pos_rd));

  acp_ram #(.WIDTH(32), .DEPTH(2**CB)) u_target (
    .clk, .we(tg_we), .waddr(CB'(item.param_index)), .wdata(item.value_a),
    .raddr(ck), .rdata(tg_rd));

  acp_ram #(.WIDTH(32), .DEPTH(2**WAW)) u_mwrows (
    .clk, .we(mwr_we), .waddr({cj, cr}), .wdata(prod_fx), .raddr(mwr_ra), .rdata(mwr_rd));

  acp_ram #(.WIDTH(32), .DEPTH(2**(2*CB))) u_reduced (
    .clk, .we(rm_we), .waddr({cj, ck}), .wdata(acp_pkg::sat32(acc)),
    .raddr({cj, ck}), .rdata(rm_rd));

  acp_ram #(.WIDTH(32), .DEPTH(2**CB)) u_effmass (
    .clk, .we(em_we), .waddr(cj), .wdata(acp_pkg::sat32(acc)), .raddr(cj), .rdata(em_rd));

  acp_ram #(.WIDTH(32), .DEPTH(2**CB)) u_mult (
    .clk, .we(ml_we), .waddr(ml_wa), .wdata(ml_wd), .raddr(ml_ra), .rdata(ml_rd));

  // shared multiplier operands
  always_comb begin
    unique case (state)
      S_PR_DT: begin
        mul_a = {1'b0, time_step};
        mul_b = {1'b0, time_step};
      end
      S_MW_MUL: begin
        mul_a = w_rd;
        mul_b = ms_rd[63:32];
      end
      S_RM_MUL: begin
        mul_a = mwr_rd;
        mul_b = w_rd;
      end
      S_EM_RD1, S_EM_RD2: begin
        mul_a = mwr_rd;
        mul_b = mwr_rd;
      end
      S_PJ1_MUL: begin
        mul_a = mwr_rd;
        mul_b = pos_rd;
      end
      S_PJ2_MUL: begin
        mul_a = rm_rd;
        mul_b = tg_rd;
      end
      S_PJ3_MUL1: begin
        mul_a = mwr_rd;
        mul_b = dl;
      end
      S_PJ3_MUL2: begin
        mul_a = ms_rd[31:0];
        mul_b = prod_fx;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shared divider requests
  always_comb begin
    div_go  = 1'b1;
    div_a   = '0;
    div_b   = '0;
    div_ret = S_IDLE;
    unique case (state)
      S_PR_ROT: begin
        div_a   = {1'b0, rotation_compliance};
        div_b   = prod_fx;
        div_ret = S_PR_POS;
      end
      S_PR_POS: begin
        div_a   = {1'b0, position_compliance};
        div_b   = dt2;
        div_ret = S_PR_INIT;
      end
      S_EM_SQ: begin
        div_a   = acp_pkg::sat32(acp_pkg::ext48(t1) + acp_pkg::ext48(prod_fx));
        div_b   = ms_rd[63:32];
        div_ret = S_EM_ACC;
      end
      S_PJ_DL: begin
        div_a   = acp_pkg::neg_sat(cval);
        div_b   = em_rd;
        div_ret = S_PJ_UPD;
      end
      default: div_go = 1'b0;
    endcase
  end

  assign rem_sh = {dv_rem, dv_num[47]};
  assign qbit   = rem_sh >= {1'b0, dv_den};
  assign q_new  = {dv_num[46:0], qbit};

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (result_valid && result_ready) begin
      result_valid <= 1'b0;
    end

    if (cfg_wr) begin
      unique case (paddr[4:2])
        acp_pkg::REG_ROT_COMP:  rotation_compliance <= pwdata[30:0];
        acp_pkg::REG_POS_COMP:  position_compliance <= pwdata[30:0];
        acp_pkg::REG_TIME_STEP: time_step <= pwdata[30:0];
        acp_pkg::REG_VERTS:     vertex_count <= pwdata[6:0];
        acp_pkg::REG_CONTROLS:  control_count <= pwdata[3:0];
        default: ;
      endcase
    end

    unique case (state)
      S_CLEAR: begin
        clr_cnt <= clr_cnt + 1'b1;
        if (&clr_cnt) begin
          state <= S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (item.op)
            acp_pkg::OP_PREPARE: state <= S_PR_DT;
            acp_pkg::OP_CLEAR_MULT: begin
              clr_cnt <= '0;
              state   <= S_MCLR;
            end
            acp_pkg::OP_PROJECT: begin
              cj    <= '0;
              state <= S_PJ_START;
            end
            acp_pkg::OP_READ_POS: begin
              rd_src  <= 1'b0;
              rd_zero <= !v_ok;
              state   <= S_READ;
            end
            acp_pkg::OP_READ_MULT: begin
              rd_src  <= 1'b1;
              rd_zero <= !p_ok;
              state   <= S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        result_valid      <= 1'b1;
        result.source     <= rd_src;
        result.status     <= err;
        result.data_value <= rd_zero ? '0 : (rd_src ? ml_rd : pos_rd);
        state             <= S_IDLE;
      end
      S_MCLR: begin
        clr_cnt <= clr_cnt + 1'b1;
        if (&clr_cnt[CB-1:0]) begin
          state <= S_IDLE;
        end
      end
      S_DIV: begin
        dv_rem <= qbit ? 32'(rem_sh - {1'b0, dv_den}) : rem_sh[31:0];
        dv_num <= q_new;
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_cnt == 6'(acp_pkg::DIV_STEPS - 1)) begin
          divq  <= acp_pkg::div_finish(q_new, dv_neg);
          state <= ret;
        end
      end
      S_PR_DT:  state <= S_PR_ROT;
      S_PR_ROT: dt2 <= prod_fx;
      S_PR_POS: rot_t <= divq;
      S_PR_INIT: begin
        pos_t <= divq;
        cj    <= '0;
        cr    <= '0;
        state <= S_MW_RD;
      end
      S_MW_RD:  state <= S_MW_MUL;
      S_MW_MUL: state <= S_MW_WR;
      S_MW_WR: begin
        state <= S_MW_RD;
        if (cr == rows_last) begin
          cr <= '0;
          if (cj == cols_last) begin
            cj    <= '0;
            ck    <= '0;
            acc   <= '0;
            state <= S_RM_RD;
          end else begin
            cj <= cj + 1'b1;
          end
        end else begin
          cr <= cr + 1'b1;
        end
      end
      S_RM_RD:  state <= S_RM_MUL;
      S_RM_MUL: state <= S_RM_ACC;
      S_RM_ACC: begin
        acc <= acc + acp_pkg::ext48(prod_fx);
        if (cr == rows_last) begin
          state <= S_RM_WR;
        end else begin
          cr    <= cr + 1'b1;
          state <= S_RM_RD;
        end
      end
      S_RM_WR: begin
        acc   <= '0;
        cr    <= '0;
        state <= S_RM_RD;
        if (ck == cols_last) begin
          ck <= '0;
          if (cj == cols_last) begin
            cj    <= '0;
            m3    <= '0;
            state <= S_EM_START;
          end else begin
            cj <= cj + 1'b1;
          end
        end else begin
          ck <= ck + 1'b1;
        end
      end
      S_EM_START: begin
        acc   <= acp_pkg::ext48((m3 == 2'(acp_pkg::POS_COL_PHASE)) ? pos_t : rot_t);
        cr    <= '0;
        state <= S_EM_RD0;
      end
      S_EM_RD0: state <= S_EM_RD1;
      S_EM_RD1: state <= S_EM_RD2;
      S_EM_RD2: begin
        t1    <= prod_fx;
        state <= S_EM_SQ;
      end
      S_EM_SQ: ;
      S_EM_ACC: begin
        acc <= acc + acp_pkg::ext48(divq);
        if (cr[RB-1:1] == nvm1) begin
          state <= S_EM_WR;
        end else begin
          cr    <= cr + RB'(2);
          state <= S_EM_RD0;
        end
      end
      S_EM_WR: begin
        if (cj == cols_last) begin
          state <= S_IDLE;
        end else begin
          cj    <= cj + 1'b1;
          m3    <= (m3 == 2'(acp_pkg::COL_PERIOD - 1)) ? 2'd0 : m3 + 2'd1;
          state <= S_EM_START;
        end
      end
      S_PJ_START: begin
        acc   <= '0;
        cr    <= '0;
        state <= S_PJ1_RD;
      end
      S_PJ1_RD:  state <= S_PJ1_MUL;
      S_PJ1_MUL: state <= S_PJ1_ACC;
      S_PJ1_ACC: begin
        if (cr == rows_last) begin
          s1    <= acp_pkg::sat32(acc + acp_pkg::ext48(prod_fx));
          acc   <= '0;
          ck    <= '0;
          state <= S_PJ2_RD;
        end else begin
          acc   <= acc + acp_pkg::ext48(prod_fx);
          cr    <= cr + 1'b1;
          state <= S_PJ1_RD;
        end
      end
      S_PJ2_RD:  state <= S_PJ2_MUL;
      S_PJ2_MUL: state <= S_PJ2_ACC;
      S_PJ2_ACC: begin
        acc <= acc + acp_pkg::ext48(prod_fx);
        if (ck == cols_last) begin
          state <= S_PJ_C;
        end else begin
          ck    <= ck + 1'b1;
          state <= S_PJ2_RD;
        end
      end
      S_PJ_C: begin
        cval  <= acp_pkg::sat32(acp_pkg::ext48(s1) - acp_pkg::ext48(acp_pkg::sat32(acc)));
        state <= S_PJ_DL;
      end
      S_PJ_DL: ;
      S_PJ_UPD: begin
        dl    <= divq;
        cr    <= '0;
        state <= S_PJ3_RD;
      end
      S_PJ3_RD:   state <= S_PJ3_MUL1;
      S_PJ3_MUL1: state <= S_PJ3_MUL2;
      S_PJ3_MUL2: state <= S_PJ3_WR;
      S_PJ3_WR: begin
        if (cr == rows_last) begin
          if (cj == cols_last) begin
            state <= S_IDLE;
          end else begin
            cj    <= cj + 1'b1;
            state <= S_PJ_START;
          end
        end else begin
          cr    <= cr + 1'b1;
          state <= S_PJ3_RD;
        end
      end
      default: state <= S_IDLE;
    endcase

    // divider launch; a zero divisor returns zero at once and flags it
    if (div_go) begin
      ret    <= div_ret;
      dv_num <= {acp_pkg::abs32(div_a), 16'd0};
      dv_den <= acp_pkg::abs32(div_b);
      dv_neg <= div_a[31] ^ div_b[31];
      dv_rem <= '0;
      dv_cnt <= '0;
      if (div_b == 32'sd0) begin
        divq  <= '0;
        err   <= 1'b1;
        state <= div_ret;
      end else begin
        state <= S_DIV;
      end
    end

    if (rst) begin
      state               <= S_CLEAR;
      clr_cnt             <= '0;
      err                 <= 1'b0;
      result_valid        <= 1'b0;
      rotation_compliance <= '0;
      position_compliance <= '0;
      time_step           <= acp_pkg::TIME_STEP_RESET;
      vertex_count        <= acp_pkg::VERTS_RESET;
      control_count       <= acp_pkg::CONTROLS_RESET;
    end
  end

endmodule
`default_nettype wire

### rtl/acp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module acp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### tb/sv/affine_constraint_projection_tb.sv
// Self-checking testbench for the affine constraint projection block.
`timescale 1ns / 1ps
module affine_constraint_projection_tb;
  import acp_pkg::*;

  localparam int NVERT = MAX_VERTS_DEF;
  localparam int NROW = 2 * NVERT;
  localparam int NCOL = COLS_PER_CONTROL * MAX_CONTROLS_DEF;
  localparam longint CYCLE_LIMIT = 6000000;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 0;
  out_item_t result;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #10 clk = ~clk;

  affine_constraint_projection uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the block state
  int wgt[NROW*NCOL];
  int mass[NVERT];
  int inv_mass[NVERT];
  int pos[NROW];
  int tgt[NCOL];
  int wm_rows[NCOL*NROW];
  int reduced[NCOL*NCOL];
  int eff_mass[NCOL];
  int lambda[NCOL];
  bit div_fault;
  int rot_comp, pos_comp, dt_reg, verts_reg, controls_reg;

  out_item_t readback_q[$];
  longint cycles;
  int mismatches, items_sent, results_seen, prepares, projects;
  bit steady;     // no idling on either side
  bit prepared;   // prepare done since the last register write

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic int fmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat(p >>> 16);
  endfunction

  function automatic int fdiv(int a, int b);
    if (b == 0) begin
      div_fault = 1;
      return 0;
    end
    return sat((longint'(a) * 65536) / longint'(b));
  endfunction

  function automatic int verts_used();
    if (verts_reg < 1) return 1;
    return verts_reg > NVERT ? NVERT : verts_reg;
  endfunction

  function automatic int cols_used();
    int k;
    k = controls_reg < 1 ? 1 : controls_reg;
    if (k > MAX_CONTROLS_DEF) k = MAX_CONTROLS_DEF;
    return COLS_PER_CONTROL * k;
  endfunction

  function automatic void form_system();
    int nv, rows, cols, dt2, rot, pc, ax, ay, sq;
    longint acc;
    nv = verts_used();
    rows = 2 * nv;
    cols = cols_used();
    dt2 = fmul(dt_reg, dt_reg);
    rot = fdiv(rot_comp, dt2);
    pc = fdiv(pos_comp, dt2);
    for (int j = 0; j < cols; j++)
      for (int r = 0; r < rows; r++)
        wm_rows[j*NROW + r] = fmul(wgt[r*NCOL + j], mass[r >> 1]);
    for (int j = 0; j < cols; j++)
      for (int k = 0; k < cols; k++) begin
        acc = 0;
        for (int r = 0; r < rows; r++)
          acc += fmul(wm_rows[j*NROW + r], wgt[r*NCOL + k]);
        reduced[j*NCOL + k] = sat(acc);
      end
    for (int j = 0; j < cols; j++) begin
      acc = (j % COL_PERIOD == POS_COL_PHASE) ? pc : rot;
      for (int r = 0; r < nv; r++) begin
        ax = wm_rows[j*NROW + 2*r];
        ay = wm_rows[j*NROW + 2*r + 1];
        sq = sat(longint'(fmul(ax, ax)) + fmul(ay, ay));
        acc += fdiv(sq, mass[r]);
      end
      eff_mass[j] = sat(acc);
    end
  endfunction

  function automatic void sweep();
    int rows, cols, c, dl, dx;
    longint s1, s2;
    rows = 2 * verts_used();
    cols = cols_used();
    for (int j = 0; j < cols; j++) begin
      s1 = 0;
      s2 = 0;
      for (int r = 0; r < rows; r++) s1 += fmul(wm_rows[j*NROW + r], pos[r]);
      for (int k = 0; k < cols; k++) s2 += fmul(reduced[j*NCOL + k], tgt[k]);
      c = sat(longint'(sat(s1)) - sat(s2));
      dl = fdiv(sat(-longint'(c)), eff_mass[j]);
      lambda[j] = sat(longint'(lambda[j]) + dl);
      for (int r = 0; r < rows; r++) begin
        dx = fmul(wm_rows[j*NROW + r], dl);
        pos[r] = sat(longint'(pos[r]) + fmul(inv_mass[r >> 1], dx));
      end
    end
  endfunction

  // update shadow state; returns 1 with the readback when the op gives one
  function automatic bit apply_item(in_item_t it, output out_item_t rd);
    int v, p;
    v = it.vert_index;
    p = it.param_index;
    rd = '0;
    case (it.op)
      OP_LOAD_WEIGHT: if (p < NCOL) wgt[(2*v + it.axis)*NCOL + p] = it.value_a;
      OP_LOAD_MASS: begin
        mass[v] = it.value_a;
        inv_mass[v] = it.value_b;
      end
      OP_LOAD_POS: pos[2*v + it.axis] = it.value_a;
      OP_LOAD_TARGET: if (p < NCOL) tgt[p] = it.value_a;
      OP_PREPARE: form_system();
      OP_CLEAR_MULT: foreach (lambda[i]) lambda[i] = 0;
      OP_PROJECT: sweep();
      OP_READ_POS: begin
        rd.data_value = pos[2*v + it.axis];
        rd.source = 1'b0;
        rd.status = div_fault;
        return 1;
      end
      OP_READ_MULT: begin
        rd.data_value = (p < NCOL) ? lambda[p] : 0;
        rd.source = 1'b1;
        rd.status = div_fault;
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_item(in_item_t it, bit typed = 0, out_item_t want = '0);
    out_item_t rd;
    int gap;
    gap = (!steady && $urandom_range(99) < 23) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    if (it.op == OP_PREPARE) prepares++;
    if (it.op == OP_PROJECT) projects++;
    if (apply_item(it, rd)) readback_q.push_back(typed ? want : rd);
  endtask

  // a read fences the block: once its result is back, all earlier work is done
  task automatic drain();
    in_item_t it;
    it = '0;
    it.op = OP_READ_POS;
    send_item(it);
    item_valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROT_COMP: rot_comp = int'(val & 32'h7FFF_FFFF);
      REG_POS_COMP: pos_comp = int'(val & 32'h7FFF_FFFF);
      REG_TIME_STEP: dt_reg = int'(val & 32'h7FFF_FFFF);
      REG_VERTS: verts_reg = int'(val & 32'h7F);
      REG_CONTROLS: controls_reg = int'(val & 32'hF);
      default: ;
    endcase
    prepared = 0;
  endtask

  task automatic set_regs(logic [31:0] rc, logic [31:0] pc, logic [31:0] dt,
                          logic [31:0] nv, logic [31:0] nk);
    reg_write(REG_ROT_COMP, rc);
    reg_write(REG_POS_COMP, pc);
    reg_write(REG_TIME_STEP, dt);
    reg_write(REG_VERTS, nv);
    reg_write(REG_CONTROLS, nk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0, 1: return 32'($signed($urandom_range(262144)) - 131072);
      2: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    if ($urandom_range(9) == 0) return $urandom | 32'h1;
    return $urandom_range(32'h0004_0000, 32'h0000_8000);
  endfunction

  function automatic in_item_t rand_item(bit allow_zero_mass);
    in_item_t it;
    int sel;
    it.vert_index = $urandom_range(63);
    it.axis = $urandom_range(1);
    it.param_index = $urandom_range(63);
    it.value_a = pick_value();
    it.value_b = $urandom_range(1) ? pick_value() : $urandom;
    sel = $urandom_range(99);
    if (sel < 20) it.op = OP_LOAD_POS;
    else if (sel < 40) it.op = OP_READ_POS;
    else if (sel < 55) it.op = OP_READ_MULT;
    else if (sel < 67) it.op = OP_LOAD_WEIGHT;
    else if (sel < 75) it.op = OP_LOAD_MASS;
    else if (sel < 83) it.op = OP_LOAD_TARGET;
    else if (sel < 87) it.op = OP_PREPARE;
    else if (sel < 92) it.op = OP_PROJECT;
    else if (sel < 94) it.op = OP_CLEAR_MULT;
    else if (sel < 96) it.op = 4'($urandom_range(15, 9));
    else it.op = OP_READ_MULT;
    if (it.op == OP_LOAD_MASS) begin
      it.value_a = pick_mass();
      if (allow_zero_mass && $urandom_range(3) == 0) it.value_a = 32'h0;
    end
    if (it.op == OP_LOAD_WEIGHT && $urandom_range(1)) begin
      // keep most weights on the rows and columns in play
      it.vert_index = $urandom_range(3);
      it.param_index = $urandom_range(11);
    end
    if (it.op == OP_PROJECT && !prepared) it.op = OP_PREPARE;
    return it;
  endfunction

  task automatic run_phase(int count, bit allow_zero_mass);
    in_item_t it;
    it = '0;
    it.op = OP_PREPARE;
    send_item(it);
    prepared = 1;
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3 && i < count / 2);
      send_item(rand_item(allow_zero_mass));
    end
    steady = 0;
    drain();
  endtask

  function automatic in_item_t mk(logic [3:0] op, int v, int ax, int p,
                                  logic [31:0] a, logic [31:0] b = 32'h0);
    in_item_t it;
    it.op = op;
    it.vert_index = v;
    it.axis = ax;
    it.param_index = p;
    it.value_a = a;
    it.value_b = b;
    return it;
  endfunction

  function automatic out_item_t rb(logic [31:0] d, logic src);
    out_item_t o;
    o.data_value = d;
    o.source = src;
    o.status = 1'b0;
    return o;
  endfunction

  // result checking
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (readback_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer on result: %p", result);
      end else begin
        out_item_t want;
        want = readback_q.pop_front();
        if (result.data_value !== want.data_value || result.source !== want.source ||
            result.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected data %h source %b status %b, got %h %b %b",
                     want.data_value, want.source, want.status,
                     result.data_value, result.source, result.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= steady || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  typedef struct {
    in_item_t it;
    bit typed;
    out_item_t want;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    cycles = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    prepares = 0;
    projects = 0;
    steady = 0;
    prepared = 0;
    foreach (wgt[i]) wgt[i] = 0;
    foreach (lambda[i]) lambda[i] = 0;
    div_fault = 0;
    rot_comp = 0;
    pos_comp = 0;
    dt_reg = 1092;
    verts_reg = 64;
    controls_reg = 8;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_regs(32'h0000_0100, 32'h0000_0040, 32'h0000_4000, 3, 1);

    // fill the mass, position and target stores and the weights in play
    for (int v = 0; v < NVERT; v++) begin
      send_item(mk(OP_LOAD_MASS, v, 0, 0, pick_mass(), pick_value()));
      send_item(mk(OP_LOAD_POS, v, 0, 0, pick_value()));
      send_item(mk(OP_LOAD_POS, v, 1, 0, pick_value()));
    end
    for (int p = 0; p < NCOL; p++) send_item(mk(OP_LOAD_TARGET, 0, 0, p, pick_value()));
    for (int r = 0; r < 8; r++)
      for (int p = 0; p < 12; p++)
        send_item(mk(OP_LOAD_WEIGHT, r >> 1, r & 1, p, pick_value()));

    rows.push_back('{mk(OP_READ_MULT, 0, 0, 0, 0), 1, rb(32'h0, 1)});
    rows.push_back('{mk(OP_READ_MULT, 0, 0, 63, 32'hFFFF_FFFF), 1, rb(32'h0, 1)});
    rows.push_back('{mk(4'd9, 63, 1, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, '0});
    rows.push_back('{mk(4'd15, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_LOAD_POS, 63, 1, 0, 32'h7FFF_FFFF), 0, '0});
    rows.push_back('{mk(OP_READ_POS, 63, 1, 0, 0), 1, rb(32'h7FFF_FFFF, 0)});
    rows.push_back('{mk(OP_LOAD_POS, 0, 0, 0, 32'h8000_0000), 0, '0});
    rows.push_back('{mk(OP_READ_POS, 0, 0, 0, 0), 1, rb(32'h8000_0000, 0)});
    rows.push_back('{mk(OP_LOAD_TARGET, 0, 0, 63, 32'h1234_5678), 0, '0});
    rows.push_back('{mk(OP_LOAD_WEIGHT, 63, 1, 63, 32'h7FFF_FFFF), 0, '0});
    rows.push_back('{mk(OP_LOAD_WEIGHT, 0, 1, 5, 32'h7FFF_FFFF), 0, '0});
    rows.push_back('{mk(OP_LOAD_WEIGHT, 2, 0, 0, 32'h8000_0000), 0, '0});
    rows.push_back('{mk(OP_LOAD_MASS, 1, 0, 0, 32'h0001_0000, 32'h0001_0000), 0, '0});
    rows.push_back('{mk(OP_PREPARE, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_PROJECT, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_READ_MULT, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_READ_MULT, 0, 0, 5, 0), 0, '0});
    rows.push_back('{mk(OP_READ_POS, 0, 1, 0, 0), 0, '0});
    rows.push_back('{mk(OP_PROJECT, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_READ_POS, 2, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_CLEAR_MULT, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_READ_MULT, 0, 0, 5, 0), 1, rb(32'h0, 1)});
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);
    drain();

    // register settings: ordinary ones, then the extremes
    for (int ph = 0; ph < 8; ph++) begin
      set_regs($urandom_range(32'h0004_0000), $urandom_range(32'h0004_0000),
               $urandom_range(32'h0002_0000, 32'h0000_0400),
               $urandom_range(4, 1), $urandom_range(2, 1));
      run_phase(140, 0);
    end
    set_regs(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 127, 1);
    run_phase(60, 0);
    set_regs(32'h0, 32'h7FFF_FFFF, 32'h0000_0001, 1, 15);
    run_phase(60, 0);
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 0, 0);
    run_phase(120, 0);
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 64, 8);
    reg_write(REG_VERTS, 2);
    reg_write(REG_CONTROLS, 1);
    run_phase(80, 0);
    // zero divisors last: the fault flag is sticky
    set_regs(32'h0001_0000, 32'h0001_0000, 32'h0, 3, 1);
    run_phase(80, 1);
    set_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 4, 2);
    run_phase(120, 1);

    while (readback_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d item transfers, %0d readbacks, %0d prepares, %0d projects",
             items_sent, results_seen, prepares, projects);
    $display("register settings swept incl. saturated counts and zero time step");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
